@@ src/mlc_pkg.sv @@
package mlc_pkg;

  typedef enum logic [1:0] {
    LVL_REGISTER = 2'd0,
    LVL_NEAR     = 2'd1,
    LVL_FAR      = 2'd2,
    LVL_MEMORY   = 2'd3
  } hit_level_t;

  typedef enum logic [2:0] {
    CFG_LINE_SHIFT    = 3'd0,
    CFG_REGISTER_COST = 3'd1,
    CFG_NEAR_COST     = 3'd2,
    CFG_FAR_COST      = 3'd3,
    CFG_MEMORY_COST   = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_RESOLVE,
    ST_UPDATE,
    ST_UPDATE_DRAIN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic upd_rd;
    logic resolve;
    logic finish;
  } mlc_cmd_t;

  localparam int TOTAL_W = 48;
  localparam int COST_W  = 10;
  localparam int SHIFT_W = 4;
  localparam int CFG_W   = 10;

  localparam logic [SHIFT_W-1:0] LINE_SHIFT_RST    = 4'd6;
  localparam logic [7:0]         REGISTER_COST_RST = 8'd1;
  localparam logic [7:0]         NEAR_COST_RST     = 8'd4;
  localparam logic [7:0]         FAR_COST_RST      = 8'd50;
  localparam logic [COST_W-1:0]  MEMORY_COST_RST   = 10'd190;

endpackage

@@ src/mlc_level.sv @@
module mlc_level
  import mlc_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int TAG_W = 48,
  parameter int SW_W  = 12,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  mlc_cmd_t         cmd,
  input  logic [SW_W-1:0]  idx,
  input  logic [TAG_W-1:0] tag,
  output logic             hit,
  output logic             full,
  output logic [CNT_W-1:0] count
);

  logic [TAG_W-1:0] tags [DEPTH];
  logic [IDX_W-1:0] ages [DEPTH];

  logic             rd_en;
  logic             live;
  logic             scan_d;
  logic             upd_d;
  logic             live_d;
  logic [IDX_W-1:0] idx_d;
  logic [TAG_W-1:0] tag_q;
  logic [IDX_W-1:0] age_q;
  logic [IDX_W-1:0] hit_slot;
  logic [IDX_W-1:0] hit_age;
  logic [IDX_W-1:0] old_slot;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] thr;
  logic [IDX_W-1:0] last_age;
  logic             not_full;

  assign rd_en    = (cmd.scan_rd | cmd.upd_rd) & (idx < SW_W'(DEPTH));
  assign live     = idx < SW_W'(count);
  assign full     = count == CNT_W'(DEPTH);
  assign not_full = ~full;
  assign last_age = IDX_W'(count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag_q <= tags[idx[IDX_W-1:0]];
      age_q <= ages[idx[IDX_W-1:0]];
    end
    if (cmd.resolve && !hit) begin
      tags[slot_sel()] <= tag;
    end
    if (upd_d && live_d) begin
      if (idx_d == slot) begin
        ages[idx_d] <= '0;
      end else if (age_q < thr) begin
        ages[idx_d] <= age_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_d <= 1'b0;
      upd_d  <= 1'b0;
      live_d <= 1'b0;
      hit    <= 1'b0;
      count  <= '0;
    end else begin
      scan_d <= cmd.scan_rd & rd_en;
      upd_d  <= cmd.upd_rd & rd_en;
      live_d <= rd_en & live;
      idx_d  <= idx[IDX_W-1:0];
      if (cmd.load) begin
        hit <= 1'b0;
      end else if (scan_d && live_d) begin
        if (tag_q == tag) begin
          hit      <= 1'b1;
          hit_slot <= idx_d;
          hit_age  <= age_q;
        end
        if (age_q == last_age) begin
          old_slot <= idx_d;
        end
      end
      if (cmd.resolve) begin
        slot <= slot_sel();
        thr  <= thr_sel();
        if (!hit && not_full) begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  // Target slot and age threshold: a miss into a free slot behaves as a hit
  // at the new slot whose age is the old count; a full miss hits the oldest.
  function automatic logic [IDX_W-1:0] slot_sel();
    priority if (hit) return hit_slot;
    else if (not_full) return IDX_W'(count);
    else return old_slot;
  endfunction

  function automatic logic [IDX_W-1:0] thr_sel();
    priority if (hit) return hit_age;
    else if (not_full) return IDX_W'(count);
    else return last_age;
  endfunction

endmodule

@@ src/mlc_ctrl.sv @@
module mlc_ctrl
  import mlc_pkg::*;
#(
  parameter int SW_W = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic [SW_W-1:0] sweep_len,
  output mlc_cmd_t        cmd,
  output logic [SW_W-1:0] idx
);

  ctrl_state_t     state;
  ctrl_state_t     state_next;
  logic [SW_W-1:0] idx_next;
  logic            at_end;

  assign at_end = idx == sweep_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:         if (in_valid) state_next = ST_SCAN;
      ST_SCAN:         if (at_end) state_next = ST_SCAN_DRAIN;
      ST_SCAN_DRAIN:   state_next = ST_RESOLVE;
      ST_RESOLVE:      state_next = ST_UPDATE;
      ST_UPDATE:       if (at_end) state_next = ST_UPDATE_DRAIN;
      ST_UPDATE_DRAIN: state_next = ST_DONE;
      ST_DONE:         if (!out_stall) state_next = ST_IDLE;
      default:         state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    idx_next  = idx;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        idx_next = '0;
      end
      ST_SCAN: begin
        if (!at_end) begin
          cmd.scan_rd = 1'b1;
          idx_next    = idx + SW_W'(1);
        end
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        idx_next    = '0;
      end
      ST_UPDATE: begin
        if (!at_end) begin
          cmd.upd_rd = 1'b1;
          idx_next   = idx + SW_W'(1);
        end
      end
      ST_UPDATE_DRAIN: cmd.finish = 1'b1;
      ST_DONE:         out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ src/mlc_datapath.sv @@
module mlc_datapath
  import mlc_pkg::*;
#(
  parameter int REGISTER_ENTRIES = 8,
  parameter int NEAR_LINES       = 32,
  parameter int FAR_LINES        = 2048,
  parameter int ADDRESS_BITS     = 48,
  parameter int SW_W             = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mlc_cmd_t                cmd,
  input  logic [SW_W-1:0]         idx,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic [SW_W-1:0]         sweep_len,
  output logic [1:0]              hit_level,
  output logic [COST_W-1:0]       access_cost,
  output logic [TOTAL_W-1:0]      total_ticks
);

  localparam int RC_W = $clog2(REGISTER_ENTRIES + 1);
  localparam int NC_W = $clog2(NEAR_LINES + 1);
  localparam int FC_W = $clog2(FAR_LINES + 1);

  logic [SHIFT_W-1:0]      line_shift;
  logic [7:0]              register_cost;
  logic [7:0]              near_cost;
  logic [7:0]              far_cost;
  logic [COST_W-1:0]       memory_cost;
  logic [ADDRESS_BITS-1:0] addr;
  logic [ADDRESS_BITS-1:0] line;
  logic                    reg_hit;
  logic                    near_hit;
  logic                    far_hit;
  logic                    near_full;
  logic [RC_W-1:0]         reg_count;
  logic [NC_W-1:0]         near_count;
  logic [FC_W-1:0]         far_count;
  logic [SW_W-1:0]         len_a;
  logic [SW_W-1:0]         len_b;
  hit_level_t              level_sel;
  logic [COST_W-1:0]       cost_sel;
  logic [TOTAL_W:0]        sum;

  assign line = addr >> line_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_shift    <= LINE_SHIFT_RST;
      register_cost <= REGISTER_COST_RST;
      near_cost     <= NEAR_COST_RST;
      far_cost      <= FAR_COST_RST;
      memory_cost   <= MEMORY_COST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_SHIFT:    line_shift    <= cfg_data[SHIFT_W-1:0];
        CFG_REGISTER_COST: register_cost <= cfg_data[7:0];
        CFG_NEAR_COST:     near_cost     <= cfg_data[7:0];
        CFG_FAR_COST:      far_cost      <= cfg_data[7:0];
        CFG_MEMORY_COST:   memory_cost   <= cfg_data;
        default: ;
      endcase
    end
  end

  mlc_level #(.DEPTH(REGISTER_ENTRIES), .TAG_W(ADDRESS_BITS), .SW_W(SW_W)) u_reg (
    .clk(clk), .rst(rst), .cmd(cmd), .idx(idx), .tag(addr),
    .hit(reg_hit), .full(), .count(reg_count)
  );

  mlc_level #(.DEPTH(NEAR_LINES), .TAG_W(ADDRESS_BITS), .SW_W(SW_W)) u_near (
    .clk(clk), .rst(rst), .cmd(cmd), .idx(idx), .tag(line),
    .hit(near_hit), .full(near_full), .count(near_count)
  );

  mlc_level #(.DEPTH(FAR_LINES), .TAG_W(ADDRESS_BITS), .SW_W(SW_W)) u_far (
    .clk(clk), .rst(rst), .cmd(cmd), .idx(idx), .tag(line),
    .hit(far_hit), .full(), .count(far_count)
  );

  // Sweep as far as the largest level fill count; smaller levels skip dead indexes.
  always_comb begin
    len_a     = (SW_W'(reg_count) > SW_W'(near_count)) ? SW_W'(reg_count)
                                                       : SW_W'(near_count);
    len_b     = SW_W'(far_count);
    sweep_len = (len_a > len_b) ? len_a : len_b;
  end

  always_comb begin
    priority if (reg_hit) begin
      level_sel = LVL_REGISTER;
      cost_sel  = COST_W'(register_cost);
    end else if (near_hit) begin
      level_sel = LVL_NEAR;
      cost_sel  = COST_W'(near_cost);
    end else if (far_hit) begin
      level_sel = LVL_FAR;
      cost_sel  = COST_W'(far_cost);
    end else begin
      level_sel = LVL_MEMORY;
      cost_sel  = memory_cost;
    end
    sum = {1'b0, total_ticks} + (TOTAL_W + 1)'(cost_sel);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_ticks <= '0;
    end else if (cmd.resolve) begin
      total_ticks <= sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    end else if (cmd.finish && !near_full) begin
      total_ticks <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      hit_level   <= level_sel;
      access_cost <= cost_sel;
    end
  end

endmodule

@@ src/multilevel_lru_cache_latency_model.sv @@
// Channel  Handshake               Payload
// -------  ----------------------  ---------------------------------------
// in       in_valid / in_stall     address
// out      out_valid / out_stall   hit_level, access_cost, total_ticks
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One access at a time: each access runs a search sweep over the largest level fill count
// (up to the largest level depth) before the access, then an age update sweep over the largest
// fill count after it; the block passes through idle before the next input beat.
// One tag/age memory entry is read per cycle in the search and age update sweeps.
// Reset (rst, synchronous) empties all levels via fill counts; no clearing pass.
// in_stall stays high from acceptance until the result beat is taken.
// cfg_ready is always high; write only while idle.
module multilevel_lru_cache_latency_model
  import mlc_pkg::*;
#(
  parameter int REGISTER_ENTRIES = 8,
  parameter int NEAR_LINES       = 32,
  parameter int FAR_LINES        = 2048,
  parameter int ADDRESS_BITS     = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ADDRESS_BITS-1:0] address,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              hit_level,
  output logic [COST_W-1:0]       access_cost,
  output logic [TOTAL_W-1:0]      total_ticks,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  // Sweep index must reach the largest level depth itself.
  localparam int MAX_A = (REGISTER_ENTRIES > NEAR_LINES) ? REGISTER_ENTRIES : NEAR_LINES;
  localparam int MAX_D = (MAX_A > FAR_LINES) ? MAX_A : FAR_LINES;
  localparam int SW_W  = $clog2(MAX_D + 1);

  mlc_cmd_t        cmd;
  logic [SW_W-1:0] idx;
  logic [SW_W-1:0] sweep_len;

  assign cfg_ready = 1'b1;

  // Sequence the search sweep, resolve, update sweep and result beat.
  mlc_ctrl #(.SW_W(SW_W)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .sweep_len(sweep_len), .cmd(cmd), .idx(idx)
  );

  // Hold config, the three LRU levels and the tick total.
  mlc_datapath #(
    .REGISTER_ENTRIES(REGISTER_ENTRIES),
    .NEAR_LINES(NEAR_LINES),
    .FAR_LINES(FAR_LINES),
    .ADDRESS_BITS(ADDRESS_BITS),
    .SW_W(SW_W)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .idx(idx), .address(address),
    .cfg_we(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sweep_len(sweep_len), .hit_level(hit_level),
    .access_cost(access_cost), .total_ticks(total_ticks)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("accept did not start a search");

  a_sweep_bounded: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_rd || cmd.upd_rd) |-> (idx < sweep_len))
    else $error("sweep index past fill count");

endmodule

@@ test/tb_top.sv @@
module tb_top;
  import mlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W = 48;
  localparam int REG_CAP = 8;
  localparam int NEAR_CAP = 32;
  localparam int FAR_CAP = 2048;
  localparam int RANDOM_ITEMS = 280;
  localparam int PHASES = 5;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 400;
  localparam logic [2:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [TOTAL_W-1:0] TICKS_MAX = '1;

  typedef struct {
    hit_level_t lvl;
    logic [COST_W-1:0] cost;
    logic [TOTAL_W-1:0] ticks;
  } access_res_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    bit chk;
    access_res_t res;
  } dir_row_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [ADDR_W-1:0] address;
  logic out_valid, out_stall;
  logic [1:0] hit_level;
  logic [COST_W-1:0] access_cost;
  logic [TOTAL_W-1:0] total_ticks;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  multilevel_lru_cache_latency_model dut (.*);

  // Predictor state: each level kept as a recency list, most recent first.
  logic [ADDR_W-1:0] reg_lru[$];
  logic [ADDR_W-1:0] near_lru[$];
  logic [ADDR_W-1:0] far_lru[$];
  logic [TOTAL_W-1:0] tick_acc;
  logic [3:0] shift_cfg;
  logic [7:0] reg_cost_cfg, near_cost_cfg, far_cost_cfg;
  logic [9:0] mem_cost_cfg;

  access_res_t pending_res[$];
  int errors;
  int idle_cycles;
  int hold_req;
  int pred_count;
  bit quiet;

  // Clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic bit lru_holds(ref logic [ADDR_W-1:0] q[$], input logic [ADDR_W-1:0] tag);
    foreach (q[i]) if (q[i] == tag) return 1;
    return 0;
  endfunction

  // Move or insert the tag at the front; drop the least recent on overflow.
  function automatic void lru_refresh(ref logic [ADDR_W-1:0] q[$], input int cap,
                                      input logic [ADDR_W-1:0] tag);
    int pos;
    pos = -1;
    foreach (q[i]) if (q[i] == tag) pos = i;
    if (pos >= 0) q.delete(pos);
    else if (q.size() >= cap) void'(q.pop_back());
    q.push_front(tag);
  endfunction

  function automatic access_res_t cache_access(logic [ADDR_W-1:0] addr);
    access_res_t r;
    logic [ADDR_W-1:0] line;
    line = addr >> shift_cfg;
    if (lru_holds(reg_lru, addr)) begin
      r.lvl = LVL_REGISTER; r.cost = reg_cost_cfg;
    end else if (lru_holds(near_lru, line)) begin
      r.lvl = LVL_NEAR; r.cost = near_cost_cfg;
    end else if (lru_holds(far_lru, line)) begin
      r.lvl = LVL_FAR; r.cost = far_cost_cfg;
    end else begin
      r.lvl = LVL_MEMORY; r.cost = mem_cost_cfg;
    end
    // saturate the running total
    if (tick_acc > TICKS_MAX - r.cost) tick_acc = TICKS_MAX;
    else tick_acc = tick_acc + r.cost;
    lru_refresh(reg_lru, REG_CAP, addr);
    lru_refresh(near_lru, NEAR_CAP, line);
    lru_refresh(far_lru, FAR_CAP, line);
    // warm-up: hold the total at zero until the near level is full
    if (near_lru.size() < NEAR_CAP) tick_acc = '0;
    r.ticks = tick_acc;
    return r;
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_LINE_SHIFT: begin
        shift_cfg = data[3:0];
      end
      CFG_REGISTER_COST: begin
        reg_cost_cfg = data[7:0];
      end
      CFG_NEAR_COST: begin
        near_cost_cfg = data[7:0];
      end
      CFG_FAR_COST: begin
        far_cost_cfg = data[7:0];
      end
      CFG_MEMORY_COST: begin
        mem_cost_cfg = data[9:0];
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Monitor: sample every handshake at the edge, predict on input beats,
  // check output beats against the oldest prediction.
  always @(posedge clk) begin
    access_res_t want;
    bit moved;
    moved = 0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        apply_cfg(cfg_index, cfg_data);
        moved = 1;
      end
      if (in_valid && !in_stall) begin
        pending_res.insert(pending_res.size(), cache_access(address));
        pred_count++;
        moved = 1;
      end
      if (out_valid && !out_stall) begin
        moved = 1;
        if (pending_res.size() == 0) begin
          report("unexpected beat", {hit_level, access_cost}, 0);
        end else begin
          want = pending_res[0];
          pending_res.delete(0);
          if (hit_level !== want.lvl) report("hit_level", hit_level, want.lvl);
          if (access_cost !== want.cost) report("access_cost", access_cost, want.cost);
          if (total_ticks !== want.ticks) report("total_ticks", total_ticks, want.ticks);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[multilevel_lru_cache_latency_model] ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall per beat, quiet stretches, one long hold-off on request.
  initial begin
    int k;
    out_stall <= 1'b0;
    wait (!rst);
    forever begin
      if (hold_req > 0) begin
        k = hold_req;
        hold_req = 0;
      end else begin
        k = quiet ? 0 : $urandom_range(0, 15);
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Send one address beat; lower valid only when a gap is drawn.
  task automatic send_access(logic [ADDR_W-1:0] a);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    address <= a;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain results, then let the block settle before touching registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Hold valid high across a batch of writes; the caller drops it afterwards.
  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Directed accesses at reset settings; warm-up keeps every total at zero here.
  dir_row_t dir_rows[] = '{
    '{48'h0, 1, '{LVL_MEMORY, 10'd190, 48'h0}},
    '{48'h0, 1, '{LVL_REGISTER, 10'd1, 48'h0}},
    '{ADDR_ONES, 1, '{LVL_MEMORY, 10'd190, 48'h0}},
    '{48'hFFFF_FFFF_FFC0, 1, '{LVL_NEAR, 10'd4, 48'h0}},
    '{48'h1, 1, '{LVL_NEAR, 10'd4, 48'h0}},
    '{48'h8000_0000_0000, 1, '{LVL_MEMORY, 10'd190, 48'h0}},
    '{48'h5555_5555_5555, 0, '{LVL_MEMORY, 10'd0, 48'h0}},
    '{48'hAAAA_AAAA_AAAA, 0, '{LVL_MEMORY, 10'd0, 48'h0}},
    '{48'h0000_0000_003F, 0, '{LVL_MEMORY, 10'd0, 48'h0}},
    '{48'h0000_0000_0040, 0, '{LVL_MEMORY, 10'd0, 48'h0}},
    '{48'h5555_5555_5555, 0, '{LVL_MEMORY, 10'd0, 48'h0}}
  };

  logic [ADDR_W-1:0] addr_pool[48];

  function automatic logic [ADDR_W-1:0] pick_address(logic [ADDR_W-1:0] prev);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return addr_pool[$urandom_range(0, 47)] + $urandom_range(0, 255);
    if (sel < 85) return prev;
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  initial begin
    logic [ADDR_W-1:0] last_addr;
    logic [CFG_W-1:0] phase_cfg[PHASES][5];
    errors = 0;
    idle_cycles = 0;
    hold_req = 0;
    pred_count = 0;
    quiet = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    address <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_LINE_SHIFT;
    cfg_data <= '0;
    shift_cfg = LINE_SHIFT_RST;
    reg_cost_cfg = REGISTER_COST_RST;
    near_cost_cfg = NEAR_COST_RST;
    far_cost_cfg = FAR_COST_RST;
    mem_cost_cfg = MEMORY_COST_RST;
    tick_acc = '0;
    foreach (addr_pool[i]) addr_pool[i] = ADDR_W'({$urandom(), $urandom()});
    // extremes first, then a fixed wide pattern and random settings; wide data exercises masking
    phase_cfg[0] = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
    phase_cfg[1] = '{10'd15, 10'd255, 10'd255, 10'd255, 10'd1023};
    phase_cfg[2] = '{10'd12, 10'h3FF, 10'h300, 10'h2AA, 10'h155};
    for (int p = 3; p < PHASES; p++) begin
      phase_cfg[p][0] = CFG_W'($urandom_range(0, 1023));
      for (int r = 1; r < 5; r++) phase_cfg[p][r] = CFG_W'($urandom_range(0, 1023));
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table; rows with typed results must also agree with the predictor.
    foreach (dir_rows[i]) begin
      send_access(dir_rows[i].addr);
      wait (pred_count == i + 1);
      if (dir_rows[i].chk) begin
        access_res_t p;
        p = pending_res[pending_res.size() - 1];
        if (p.lvl !== dir_rows[i].res.lvl || p.cost !== dir_rows[i].res.cost ||
            p.ticks !== dir_rows[i].res.ticks)
          report("directed row", i, 0);
      end
    end
    last_addr = '0;

    for (int p = 0; p < PHASES; p++) begin
      // pause the sender until every result is back, then reprogram
      wait_drained();
      for (int r = 0; r < 5; r++) write_reg(r[2:0], phase_cfg[p][r]);
      // unused index: must be ignored
      write_reg(CFG_SPARE_FIRST + 3'(p % 3), CFG_W'($urandom_range(0, 1023)));
      cfg_valid <= 1'b0;
      quiet = (p == 2);
      if (p == 1) begin
        quiet = 1;
        hold_req = LONG_HOLD;
      end
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        last_addr = pick_address(last_addr);
        send_access(last_addr);
      end
    end
    quiet = 0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("[multilevel_lru_cache_latency_model] OK");
    end else begin
      $display("[multilevel_lru_cache_latency_model] ERROR");
    end
    $finish;
  end

endmodule
